### design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a property at the same edge.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a property at the next edge.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/spf_pkg.sv
package spf_pkg;
    localparam int MaxVerticesDef = 16;
    localparam int CoordBits = 10;
    localparam int FieldBits = 10;
    localparam int ResultLimit = 8;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_SCAN = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear;
        logic append;
        logic scan_start;
        logic edge_load;
        logic div_start;
        logic insert;
        logic emit_load;
    } spf_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic edge_hit;
        logic last_edge;
        logic div_done;
        logic ins_done;
    } spf_sts_t;
endpackage

### design/spf_ctrl.sv
module spf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [1:0]        in_mode,
    output logic              in_ready,
    input  logic              emit_busy,
    output spf_pkg::spf_cmd_t cmd,
    input  spf_pkg::spf_sts_t sts
);
    import spf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EDGE = 3'd1;
    localparam logic [2:0] S_TEST = 3'd2;
    localparam logic [2:0] S_DIV = 3'd3;
    localparam logic [2:0] S_INS = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE) && !emit_busy;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    case (in_mode)
                        MODE_CLEAR: cmd.clear = 1'b1;
                        MODE_APPEND: cmd.append = 1'b1;
                        MODE_SCAN: begin
                            cmd.scan_start = 1'b1;
                            state_next = S_EDGE;
                        end
                        default: ;
                    endcase
                end
            end
            S_EDGE: begin
                // An empty store has no edge to load.
                if (sts.last_edge) begin
                    state_next = S_EMIT;
                end else begin
                    cmd.edge_load = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_TEST: begin
                if (sts.edge_hit) begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end else if (sts.last_edge) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_EDGE;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    cmd.insert = 1'b1;
                    state_next = S_INS;
                end
            end
            S_INS: begin
                if (sts.ins_done) state_next = sts.last_edge ? S_EMIT : S_EDGE;
            end
            S_EMIT: begin
                cmd.emit_load = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

### design/spf_dp.sv
module spf_dp #(
    parameter int MAX_VERTICES = spf_pkg::MaxVerticesDef
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  spf_pkg::spf_cmd_t             cmd,
    output spf_pkg::spf_sts_t             sts,
    input  logic [spf_pkg::FieldBits-1:0] in_x,
    input  logic [spf_pkg::FieldBits-1:0] in_y,
    input  logic [spf_pkg::FieldBits-1:0] in_row,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [spf_pkg::FieldBits-1:0] out_y,
    output logic [spf_pkg::FieldBits-1:0] out_xs,
    output logic [spf_pkg::FieldBits-1:0] out_xe,
    output logic                          out_span_valid,
    output logic                          out_last,
    output logic                          out_ovf,
    output logic                          emit_busy
);
    import spf_pkg::*;

    localparam int COORD_BITS = CoordBits;
    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int QW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam int SW = $clog2(ResultLimit + 1);

    logic [COORD_BITS-1:0] vx_mem [MAX_VERTICES];
    logic [COORD_BITS-1:0] vy_mem [MAX_VERTICES];
    logic [COORD_BITS-1:0] xl_reg [MAX_VERTICES];
    logic [CW-1:0] vcount_reg;
    logic ovf_reg;
    logic [CW-1:0] n_reg, edge_reg, xcnt_reg, ipos_reg;
    logic [FieldBits-1:0] row_reg;

    // Edge endpoints, read one pair per edge.
    logic [COORD_BITS-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [IW-1:0] ia, ib;
    logic [CW-1:0] nxt;

    assign nxt = edge_reg + CW'(1);
    assign ia = edge_reg[IW-1:0];
    assign ib = (nxt < n_reg) ? nxt[IW-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (cmd.append && vcount_reg < CW'(MAX_VERTICES)) begin
            vx_mem[vcount_reg[IW-1:0]] <= in_x[COORD_BITS-1:0];
            vy_mem[vcount_reg[IW-1:0]] <= in_y[COORD_BITS-1:0];
        end
        if (cmd.edge_load) begin
            x0_reg <= vx_mem[ia];
            y0_reg <= vy_mem[ia];
            x1_reg <= vx_mem[ib];
            y1_reg <= vy_mem[ib];
        end
    end

    // Ordered edge endpoints and hit test.
    logic up;
    logic [COORD_BITS-1:0] xa, ya, xb, yb;
    logic [FieldBits:0] rowe;
    assign up = y0_reg < y1_reg;
    assign xa = up ? x0_reg : x1_reg;
    assign ya = up ? y0_reg : y1_reg;
    assign xb = up ? x1_reg : x0_reg;
    assign yb = up ? y1_reg : y0_reg;
    assign rowe = {1'b0, row_reg};
    assign sts.edge_hit = (y0_reg != y1_reg) && (rowe >= (FieldBits+1)'(ya))
                          && (rowe < (FieldBits+1)'(yb));
    assign sts.last_edge = (edge_reg >= n_reg);

    // Restoring divider, one quotient bit per cycle, on magnitudes.
    logic [PW-1:0] num_reg, rem_reg;
    logic [COORD_BITS-1:0] den_reg, xa_reg;
    logic neg_reg;
    logic [PW-1:0] quo_reg;
    logic [$clog2(PW+1)-1:0] dcnt_reg;
    logic dbusy_reg, ddone_reg;
    logic signed [COORD_BITS+1:0] dx;
    logic [COORD_BITS+1:0] adx;
    logic [COORD_BITS-1:0] dr;
    logic [PW-1:0] prod;
    logic [PW:0] trial;

    assign dx = $signed({2'b00, xb}) - $signed({2'b00, xa});
    assign adx = dx[COORD_BITS+1] ? $unsigned(-dx) : $unsigned(dx);
    assign dr = COORD_BITS'(row_reg) - ya;
    assign prod = PW'(dr) * PW'(adx);
    assign trial = {rem_reg, num_reg[PW-1]} - (PW+1)'(den_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
        end else begin
            // Raise the done flag as the last quotient bit lands.
            ddone_reg <= dbusy_reg && dcnt_reg == ($clog2(PW+1))'(PW - 1);
            if (cmd.div_start) begin
                dbusy_reg <= 1'b1;
                dcnt_reg <= '0;
                num_reg <= prod;
                rem_reg <= '0;
                quo_reg <= '0;
                den_reg <= yb - ya;
                neg_reg <= dx[COORD_BITS+1];
                xa_reg <= xa;
            end else if (dbusy_reg) begin
                if (!trial[PW]) begin
                    rem_reg <= trial[PW-1:0];
                    quo_reg <= {quo_reg[PW-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[PW-2:0], num_reg[PW-1]};
                    quo_reg <= {quo_reg[PW-2:0], 1'b0};
                end
                num_reg <= {num_reg[PW-2:0], 1'b0};
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == ($clog2(PW+1))'(PW - 1)) dbusy_reg <= 1'b0;
            end
        end
    end
    assign sts.div_done = ddone_reg;

    // Crossing value: floor for negative slope rounds magnitude up.
    logic [COORD_BITS-1:0] cx_reg;
    logic [QW-1:0] qmag;
    logic exact;
    assign exact = (rem_reg == '0);
    assign qmag = QW'(quo_reg) + ((neg_reg && !exact) ? QW'(1) : QW'(0));

    // Insertion: shift one entry per cycle from the tail.
    logic inserting_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= '0;
            ovf_reg <= 1'b0;
            inserting_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                vcount_reg <= '0;
                ovf_reg <= 1'b0;
            end
            if (cmd.append) begin
                if (vcount_reg < CW'(MAX_VERTICES)) vcount_reg <= vcount_reg + 1'b1;
                else ovf_reg <= 1'b1;
            end
            if (cmd.insert) begin
                inserting_reg <= 1'b1;
                ipos_reg <= xcnt_reg;
                cx_reg <= neg_reg ? xa_reg - COORD_BITS'(qmag)
                                  : xa_reg + COORD_BITS'(qmag);
            end else if (inserting_reg) begin
                if (ipos_reg != '0 && xl_reg[ipos_reg[IW-1:0] - 1'b1] > cx_reg) begin
                    xl_reg[ipos_reg[IW-1:0]] <= xl_reg[ipos_reg[IW-1:0] - 1'b1];
                    ipos_reg <= ipos_reg - 1'b1;
                end else begin
                    xl_reg[ipos_reg[IW-1:0]] <= cx_reg;
                    xcnt_reg <= xcnt_reg + 1'b1;
                    inserting_reg <= 1'b0;
                end
            end
            if (cmd.scan_start) begin
                n_reg <= vcount_reg;
                row_reg <= in_row;
                edge_reg <= '0;
                xcnt_reg <= '0;
            end
            if (cmd.edge_load) edge_reg <= nxt;
        end
    end
    assign sts.ins_done = inserting_reg &&
        !(ipos_reg != '0 && xl_reg[ipos_reg[IW-1:0] - 1'b1] > cx_reg);

    // Span emitter with an output register.
    logic [SW-1:0] nsp_reg, k_reg;
    logic ebusy_reg, ov_reg;
    logic eload;
    logic [CW-1:0] half;
    assign half = xcnt_reg >> 1;
    assign eload = ebusy_reg && (!ov_reg || out_ready);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ebusy_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (eload) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
            if (cmd.emit_load) begin
                ebusy_reg <= 1'b1;
                k_reg <= '0;
                nsp_reg <= (half > CW'(ResultLimit)) ? SW'(ResultLimit) : SW'(half);
            end else if (eload) begin
                out_y <= row_reg;
                out_ovf <= ovf_reg;
                if (nsp_reg == '0) begin
                    out_xs <= '0;
                    out_xe <= '0;
                    out_span_valid <= 1'b0;
                    out_last <= 1'b1;
                    ebusy_reg <= 1'b0;
                end else begin
                    out_xs <= FieldBits'(xl_reg[IW'({k_reg, 1'b0})]);
                    out_xe <= FieldBits'(xl_reg[IW'({k_reg, 1'b1})]);
                    out_span_valid <= 1'b1;
                    out_last <= (k_reg == nsp_reg - 1'b1);
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == nsp_reg - 1'b1) ebusy_reg <= 1'b0;
                end
            end
        end
    end
    assign out_valid = ov_reg;
    assign emit_busy = ebusy_reg;
endmodule

### design/scanline_polygon_span_fill.sv
// Scan-line polygon span generator, even-odd rule. Mode 0 clears the vertex
// store, mode 1 appends a vertex (extras past MAX_VERTICES are dropped and set a
// sticky overflow flag) and mode 3 is ignored. Mode 2 scans one row: every
// closed edge passes through an edge-load state and a test state, and an edge
// the row cuts adds a bit-serial divide and an insertion that shifts each
// stored crossing lying to its right. An emit state then starts the span
// emitter, which sends up to 8 spans at one per cycle while m_ready is high.
// An empty row gives one result with m_span_valid low. A new transaction is
// accepted once the last result of the row sits in the output register. The
// shared divider sets the row time.
module scanline_polygon_span_fill #(
    parameter int MAX_VERTICES = spf_pkg::MaxVerticesDef
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic [spf_pkg::FieldBits-1:0] s_vert_x,
    input  logic [spf_pkg::FieldBits-1:0] s_vert_y,
    input  logic [spf_pkg::FieldBits-1:0] s_scan_row,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [spf_pkg::FieldBits-1:0] m_span_y,
    output logic [spf_pkg::FieldBits-1:0] m_span_x_start,
    output logic [spf_pkg::FieldBits-1:0] m_span_x_end,
    output logic                          m_span_valid,
    output logic                          m_last_span,
    output logic                          m_vertex_overflow
);
    import spf_pkg::*;

    spf_cmd_t cmd;
    spf_sts_t sts;
    logic emit_busy;

    spf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_mode(s_mode),
        .in_ready(s_ready), .emit_busy(emit_busy),
        .cmd(cmd), .sts(sts)
    );

    spf_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_x(s_vert_x), .in_y(s_vert_y), .in_row(s_scan_row),
        .out_valid(m_valid), .out_ready(m_ready), .out_y(m_span_y),
        .out_xs(m_span_x_start), .out_xe(m_span_x_end),
        .out_span_valid(m_span_valid), .out_last(m_last_span),
        .out_ovf(m_vertex_overflow), .emit_busy(emit_busy)
    );
endmodule

### design/spf_checker.sv
`include "assert_macros.svh"
module spf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [9:0] m_span_y,
    input logic [9:0] m_span_x_start,
    input logic [9:0] m_span_x_end,
    input logic       m_span_valid,
    input logic       m_last_span,
    input logic       m_vertex_overflow
);
    // An empty-row result is always the last of its row.
    `ASSERT_IMPLY(a_empty_last, aclk, aresetn, m_valid && !m_span_valid, m_last_span)
    // An empty-row result carries zero coordinates.
    `ASSERT_IMPLY(a_empty_zero, aclk, aresetn, m_valid && !m_span_valid, (m_span_x_start == 10'd0) && (m_span_x_end == 10'd0))
    // Hold a waiting result until its transaction completes.
    `ASSERT_NEXT(a_valid_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    // Keep the payload of a waiting result unchanged.
    `ASSERT_NEXT(a_data_hold, aclk, aresetn, m_valid && !m_ready, $stable({m_span_y, m_span_x_start, m_span_x_end, m_span_valid, m_last_span, m_vertex_overflow}))
endmodule

bind scanline_polygon_span_fill spf_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_span_y(m_span_y), .m_span_x_start(m_span_x_start),
    .m_span_x_end(m_span_x_end), .m_span_valid(m_span_valid),
    .m_last_span(m_last_span), .m_vertex_overflow(m_vertex_overflow)
);
